### sv/ds_pkg.sv
// shared constants and types for the divisor sum block
package ds_pkg;

    localparam int TOTAL_BITS = 36;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_CHECK = 5'b00100,
        S_ADDQ  = 5'b01000,
        S_WAIT  = 5'b10000
    } t_state;

endpackage

### sv/ds_in_if.sv
// input channel carrying the number whose divisors are summed
interface ds_in_if #(
    parameter int NUMBER_BITS = 32
);
    logic                   valid;
    logic                   ready;
    logic [NUMBER_BITS-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

### sv/ds_out_if.sv
// output channel carrying the divisor total
interface ds_out_if
    import ds_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [TOTAL_BITS-1:0] divisor_total;

    modport source (output valid, output divisor_total, input ready);
    modport sink   (input valid, input divisor_total, output ready);
endinterface

### sv/divisor_sum.sv
// divisor sum: trial division with one shared restoring divider
// work per item: a full division for each candidate divisor from 1 until its square exceeds n, plus an S_ADDQ
//   step for each divisor pair found; the divider yields one quotient bit per cycle
// throughput: one item at a time, the next item is taken once the sequencer is idle
// reset: synchronous active-low i_rst_n clears the sequencer and output valid
module divisor_sum
    import ds_pkg::*;
#(
    parameter int NUMBER_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ds_in_if.sink          i_in,
    ds_out_if.source       o_out
);

    // candidate divisor width: covers floor(sqrt(2^NUMBER_BITS - 1)) + 1
    localparam int D_BITS   = (NUMBER_BITS + 1) / 2 + 1;
    localparam int CNT_BITS = $clog2(NUMBER_BITS);
    localparam int PAD_BITS = NUMBER_BITS - D_BITS;

    t_state                   r_state, n_state;
    logic [NUMBER_BITS-1:0]   r_num,   n_num;     // dividend held for the whole item
    logic [D_BITS-1:0]        r_d,     n_d;       // current candidate divisor
    logic [NUMBER_BITS-1:0]   r_quo,   n_quo;     // dividend shifting out, quotient shifting in
    logic [D_BITS-1:0]        r_rem,   n_rem;     // partial remainder, always below r_d
    logic [CNT_BITS-1:0]      r_cnt,   n_cnt;     // divider bit counter
    logic [TOTAL_BITS-1:0]    r_total, n_total;   // running divisor sum
    logic                     r_out_valid, n_out_valid;
    logic [TOTAL_BITS-1:0]    r_out,   n_out;

    // one restoring division step
    logic [D_BITS:0]          rem_shift;
    logic [D_BITS:0]          rem_diff;
    logic                     quo_bit;
    logic [NUMBER_BITS-1:0]   d_wide;
    logic                     out_free;

    assign rem_shift = {r_rem, r_quo[NUMBER_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, r_d};
    assign quo_bit   = ~rem_diff[D_BITS];
    assign d_wide    = {{PAD_BITS{1'b0}}, r_d};
    assign out_free  = ~r_out_valid | o_out.ready;

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.divisor_total = r_out;

    always_comb begin
        n_state     = r_state;
        n_num       = r_num;
        n_d         = r_d;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_total     = r_total;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~o_out.ready;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    // first candidate is 1
                    n_num   = i_in.number;
                    n_d     = D_BITS'(1);
                    n_quo   = i_in.number;
                    n_rem   = '0;
                    n_cnt   = CNT_BITS'(NUMBER_BITS - 1);
                    n_total = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_quo = {r_quo[NUMBER_BITS-2:0], quo_bit};
                n_rem = quo_bit ? rem_diff[D_BITS-1:0] : rem_shift[D_BITS-1:0];
                n_cnt = r_cnt - CNT_BITS'(1);
                if (r_cnt == '0) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                // quotient below candidate means candidate squared exceeds n
                if (r_quo < d_wide) begin
                    n_state = S_WAIT;
                end else if (r_rem == '0) begin
                    n_total = r_total + TOTAL_BITS'(r_d);
                    n_state = S_ADDQ;
                end else begin
                    n_d     = r_d + D_BITS'(1);
                    n_quo   = r_num;
                    n_rem   = '0;
                    n_cnt   = CNT_BITS'(NUMBER_BITS - 1);
                    n_state = S_DIV;
                end
            end
            S_ADDQ: begin
                // partner counted once for a perfect square
                if (r_quo != d_wide) begin
                    n_total = r_total + TOTAL_BITS'(r_quo);
                end
                n_d     = r_d + D_BITS'(1);
                n_quo   = r_num;
                n_rem   = '0;
                n_cnt   = CNT_BITS'(NUMBER_BITS - 1);
                n_state = S_DIV;
            end
            S_WAIT: begin
                // hand the total over once the output register is free
                if (out_free) begin
                    n_out       = r_total;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num   <= n_num;
        r_d     <= n_d;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_total <= n_total;
        r_out   <= n_out;
    end

    // remainder stays below the candidate once a division completes
    a_rem_below_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_rem < r_d))
        else $error("remainder not below candidate divisor");

    // last divider step always leads to the check
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_CHECK))
        else $error("divider did not finish into check");

    // adding a divisor pair restarts division on the next candidate
    a_addq_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADDQ) |=> (r_state == S_DIV && r_d == $past(r_d) + D_BITS'(1)))
        else $error("candidate not advanced after divisor pair");

endmodule

### tb/sv/tb_top.sv
// self-checking testbench for the divisor sum block: predictor, driver, monitor and stimulus
`timescale 1ns / 100ps

module tb_top
    import ds_pkg::*;
();

    localparam int NUMBER_BITS = 32;
    // the longest correct run is dominated by the all-ones number
    localparam longint CYCLE_LIMIT = 20_000_000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_OFF_CYCLES = 3000;

    logic i_clk;
    logic i_rst_n;

    ds_in_if #(.NUMBER_BITS(NUMBER_BITS)) in_ch ();
    ds_out_if out_ch ();

    divisor_sum #(
        .NUMBER_BITS(NUMBER_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // numbers waiting to be offered, and totals waiting to come out
    logic [NUMBER_BITS-1:0] numbers_waiting[$];
    logic [TOTAL_BITS-1:0]  sigma_due[$];
    logic [NUMBER_BITS-1:0] number_due[$];

    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_left      = 0;
    logic   in_took        = 1'b0;
    int     items_queued   = 0;
    int     items_taken    = 0;
    int     results_seen   = 0;
    int     mismatches     = 0;
    int     squares_sent   = 0;
    longint cycles         = 0;

    // clock: 10 ns period
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sum of all positive divisors, pairing each divisor below the root with its partner
    function automatic logic [TOTAL_BITS-1:0] divisor_sigma(input logic [NUMBER_BITS-1:0] num);
        longint unsigned n;
        longint unsigned d;
        longint unsigned partner;
        longint unsigned total;
        n     = 64'(num);
        total = 0;
        // zero has no divisors to add, so the total stays at zero
        for (d = 1; d * d <= n; d++) begin
            if (n % d == 0) begin
                partner = n / d;
                total += d;
                // a perfect square counts its root once
                if (partner != d)
                    total += partner;
            end
        end
        return total[TOTAL_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    // random number, mostly small so the trial division stays short
    function automatic logic [NUMBER_BITS-1:0] random_number();
        int unsigned roll;
        int unsigned root;
        roll = $urandom_range(99);
        if (roll < 10) begin
            // perfect square, to exercise the shared root
            root = $urandom_range(2047, 1);
            return root * root;
        end else if (roll < 70) begin
            return $urandom_range(4095, 1);
        end else if (roll < 95) begin
            return $urandom_range(262143, 1);
        end else begin
            return $urandom_range(4194303, 1);
        end
    endfunction

    task automatic queue_number(input logic [NUMBER_BITS-1:0] num);
        numbers_waiting.push_back(num);
        items_queued++;
    endtask

    // wait until every queued item has produced its total
    task automatic drain_results();
        while (results_seen < items_queued)
            @(posedge i_clk);
    endtask

    task automatic run_random_phase(input int n_items, input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (n_items) queue_number(random_number());
        drain_results();
    endtask

    // input side: record the predicted total for each accepted item
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            sigma_due.push_back(divisor_sigma(in_ch.number));
            number_due.push_back(in_ch.number);
            items_taken++;
            in_took <= 1'b1;
        end else begin
            in_took <= 1'b0;
        end
    end

    // driver: offers the next number at the falling edge, with random idle gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            in_ch.number <= '0;
        end else if (!in_ch.valid || in_took) begin
            if (numbers_waiting.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_ch.valid  <= 1'b1;
                in_ch.number <= numbers_waiting.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver ready, held low through a hold-off stretch
    always @(negedge i_clk) begin
        if (!i_rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // hold-off counter, in cycles
    always @(posedge i_clk) begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // monitor: compare each accepted total with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (sigma_due.size() == 0) begin
                report_mismatch($sformatf("total %0d arrived with nothing outstanding",
                                          out_ch.divisor_total));
            end else begin
                if (out_ch.divisor_total !== sigma_due[0])
                    report_mismatch($sformatf("number %0d: divisor_total %0d, predicted %0d",
                                              number_due[0], out_ch.divisor_total,
                                              sigma_due[0]));
                void'(sigma_due.pop_front());
                void'(number_due.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("divisor_sum verification failed");
            $finish;
        end
    end

    initial begin
        // known values on every input from time zero
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.number = '0;
        out_ch.ready = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero, one, small primes and squares, perfect numbers, powers of two
        queue_number(32'd0);
        queue_number(32'd1);
        queue_number(32'd2);
        queue_number(32'd3);
        queue_number(32'd4);
        queue_number(32'd6);
        queue_number(32'd12);
        queue_number(32'd16);
        queue_number(32'd25);
        queue_number(32'd28);
        queue_number(32'd36);
        queue_number(32'd97);
        queue_number(32'd128);
        queue_number(32'd210);
        queue_number(32'd496);
        queue_number(32'd4093);
        queue_number(32'd65536);
        queue_number(32'd65537);
        queue_number(32'd999983);
        queue_number(32'd1000000);
        queue_number(32'd16777216);
        // all ones: the slowest item
        queue_number('1);
        drain_results();

        // random phases with different idling on each side
        run_random_phase(18, 0, 0);
        run_random_phase(18, 81, 0);
        run_random_phase(18, 0, 81);
        run_random_phase(18, 28, 28);

        // back-pressure: receiver holds off while the sender keeps offering, so the block
        // fills its output register, finishes the next item, waits on its output and stalls the input
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(negedge i_clk);
        hold_left = HOLD_OFF_CYCLES;
        repeat (6) queue_number($urandom_range(200, 1));
        drain_results();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sigma_due.size() != 0)
            report_mismatch($sformatf("%0d totals never arrived", sigma_due.size()));

        $display("summary: %0d numbers accepted, %0d totals checked, %0d mismatches",
                 items_taken, results_seen, mismatches);
        $display("summary: zero, one, primes, squares, all-ones and a long output hold-off, ",
                 "under four idling mixes");
        if (mismatches == 0) begin
            $display("divisor_sum verification clean");
        end else begin
            $display("divisor_sum verification failed");
        end
        $finish;
    end

endmodule

### files.f
sv/ds_pkg.sv
sv/ds_in_if.sv
sv/ds_out_if.sv
sv/divisor_sum.sv
tb/sv/tb_top.sv
